FILE: hdl/kem_pkg.sv
// Shared constants, register indexes and controller/datapath interface types
// for the key event queue. Used by kem_ctrl, kem_dp and the top level.
`timescale 1ns / 1ps

package kem_pkg;

    localparam int KEY_COUNT       = 512;
    localparam int SCAN_W          = 9;
    localparam int KEY_ADDR_W      = $clog2(KEY_COUNT);
    localparam int EVENT_W         = 13;
    localparam int KEY_CODE_W      = 32;
    localparam int OP_W            = 2;
    localparam int NUM_REGS        = 8;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 9;
    localparam int DEF_QUEUE_DEPTH = 16;

    // Stream payload widths, padded to whole bytes.
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 16;

    // Operation codes carried in s_tuser.
    localparam logic [OP_W-1:0] OP_KEY   = 2'd0;
    localparam logic [OP_W-1:0] OP_POP   = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_LSHIFT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RSHIFT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LALT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RALT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LCTRL  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RCTRL  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_KP_DIV = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_KP_ENT = 3'd7;

    // Reset values, highest index first.
    localparam logic [NUM_REGS-1:0][CFG_DATA_W-1:0] CFG_RESET = {
        9'd97, 9'd96, 9'd276, 9'd20, 9'd273, 9'd17, 9'd89, 9'd18
    };

    localparam logic [SCAN_W-1:0] RAW_KP_DIV   = 9'h14A;
    localparam logic [SCAN_W-1:0] RAW_KP_ENTER = 9'h15A;

    // Key map read pair selection.
    localparam logic [1:0] MAP_RD_SHIFT = 2'd0;
    localparam logic [1:0] MAP_RD_ALT   = 2'd1;
    localparam logic [1:0] MAP_RD_CTRL  = 2'd2;
    localparam logic [1:0] MAP_RD_QUERY = 2'd3;

    // Pending result load selection.
    localparam logic [2:0] RES_NONE  = 3'd0;
    localparam logic [2:0] RES_ZERO  = 3'd1;
    localparam logic [2:0] RES_DROP  = 3'd2;
    localparam logic [2:0] RES_POP   = 3'd3;
    localparam logic [2:0] RES_QUERY = 3'd4;

    typedef struct packed {
        logic       load_in;
        logic       clr_wr;
        logic       map_rd;
        logic [1:0] map_rd_sel;
        logic       cap_shift;
        logic       cap_alt;
        logic       push;
        logic       fifo_rd;
        logic       pop;
        logic [2:0] res_sel;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            full;
        logic            empty;
        logic            clr_last;
        logic            out_free;
    } status_t;

endpackage

FILE: hdl/key_event_queue_with_key_map.sv
// Top level of the key event queue with key-down map and modifier tracking.
// Instantiates kem_ctrl and kem_dp; uses kem_pkg.
`timescale 1ns / 1ps

// Each input transaction carries an operation in s_tuser: a raw key word is
// turned into a 13-bit event and queued, a pop returns the oldest event, and a
// query reports whether a scan code is held. Every transaction yields exactly
// one output transaction. After reset the block clears the key-down map and
// holds s_tready low until that is done. The key map is a single memory with
// two read ports, so a key word passes through three paired reads of the
// modifier codes and then the update; a pop or query reads and then forms its
// result, an empty pop, full-queue drop or unused operation goes straight to
// the output register, and any result may wait there on m_tready.
// Configuration writes are taken in any cycle.
module key_event_queue_with_key_map
#(
    parameter int QUEUE_DEPTH = kem_pkg::DEF_QUEUE_DEPTH
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [kem_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [kem_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // s_tdata: key_code [31:0], query_code [40:32], zero [47:41]
    input  logic [kem_pkg::S_TDATA_W-1:0]  s_tdata,
    // s_tuser: op [1:0]
    input  logic [kem_pkg::OP_W-1:0]       s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // m_tdata: event_res [12:0], event_valid [13], pressed [14], dropped [15]
    output logic [kem_pkg::M_TDATA_W-1:0]  m_tdata
);

    kem_pkg::cmd_t    cmd;
    kem_pkg::status_t status;

    kem_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    kem_dp
    #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    )
    u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

FILE: hdl/kem_ctrl.sv
// Sequencer for the key event queue: clears the key map after reset, then
// steps each transaction through its read, update and result phases. Uses kem_pkg.
`timescale 1ns / 1ps

module kem_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  kem_pkg::status_t status,
    output kem_pkg::cmd_t   cmd
);

    localparam logic [3:0] S_CLEAR    = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_DISPATCH = 4'd2;
    localparam logic [3:0] S_RD_SHIFT = 4'd3;
    localparam logic [3:0] S_RD_ALT   = 4'd4;
    localparam logic [3:0] S_RD_CTRL  = 4'd5;
    localparam logic [3:0] S_PUSH     = 4'd6;
    localparam logic [3:0] S_POP_RD   = 4'd7;
    localparam logic [3:0] S_POP      = 4'd8;
    localparam logic [3:0] S_QRY_RD   = 4'd9;
    localparam logic [3:0] S_QRY      = 4'd10;
    localparam logic [3:0] S_OUT      = 4'd11;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.res_sel    = kem_pkg::RES_NONE;
        cmd.map_rd_sel = kem_pkg::MAP_RD_QUERY;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (status.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (status.op)
                    kem_pkg::OP_KEY:
                    begin
                        if (status.full)
                        begin
                            cmd.res_sel = kem_pkg::RES_DROP;
                            state_next  = S_OUT;
                        end
                        else
                        begin
                            state_next = S_RD_SHIFT;
                        end
                    end
                    kem_pkg::OP_POP:
                    begin
                        if (status.empty)
                        begin
                            cmd.res_sel = kem_pkg::RES_ZERO;
                            state_next  = S_OUT;
                        end
                        else
                        begin
                            state_next = S_POP_RD;
                        end
                    end
                    kem_pkg::OP_QUERY:
                    begin
                        state_next = S_QRY_RD;
                    end
                    default:
                    begin
                        cmd.res_sel = kem_pkg::RES_ZERO;
                        state_next  = S_OUT;
                    end
                endcase
            end
            S_RD_SHIFT:
            begin
                cmd.map_rd     = 1'b1;
                cmd.map_rd_sel = kem_pkg::MAP_RD_SHIFT;
                state_next     = S_RD_ALT;
            end
            S_RD_ALT:
            begin
                cmd.map_rd     = 1'b1;
                cmd.map_rd_sel = kem_pkg::MAP_RD_ALT;
                cmd.cap_shift  = 1'b1;
                state_next     = S_RD_CTRL;
            end
            S_RD_CTRL:
            begin
                cmd.map_rd     = 1'b1;
                cmd.map_rd_sel = kem_pkg::MAP_RD_CTRL;
                cmd.cap_alt    = 1'b1;
                state_next     = S_PUSH;
            end
            S_PUSH:
            begin
                cmd.push    = 1'b1;
                cmd.res_sel = kem_pkg::RES_ZERO;
                state_next  = S_OUT;
            end
            S_POP_RD:
            begin
                cmd.fifo_rd = 1'b1;
                state_next  = S_POP;
            end
            S_POP:
            begin
                cmd.pop     = 1'b1;
                cmd.res_sel = kem_pkg::RES_POP;
                state_next  = S_OUT;
            end
            S_QRY_RD:
            begin
                cmd.map_rd     = 1'b1;
                cmd.map_rd_sel = kem_pkg::MAP_RD_QUERY;
                state_next     = S_QRY;
            end
            S_QRY:
            begin
                cmd.res_sel = kem_pkg::RES_QUERY;
                state_next  = S_OUT;
            end
            S_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: hdl/kem_dp.sv
// Datapath of the key event queue: configuration registers, input latch,
// key-down map memory, event FIFO memory and the output register. Uses kem_pkg.
`timescale 1ns / 1ps

module kem_dp
#(
    parameter int QUEUE_DEPTH = kem_pkg::DEF_QUEUE_DEPTH
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [kem_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [kem_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic [kem_pkg::S_TDATA_W-1:0]      s_tdata,
    input  logic [kem_pkg::OP_W-1:0]           s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [kem_pkg::M_TDATA_W-1:0]      m_tdata,
    input  kem_pkg::cmd_t                      cmd,
    output kem_pkg::status_t                   status
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;

    // Configuration registers.
    logic [kem_pkg::CFG_DATA_W-1:0] cfg_reg [kem_pkg::NUM_REGS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < kem_pkg::NUM_REGS; i++)
            begin
                cfg_reg[i] <= kem_pkg::CFG_RESET[i];
            end
        end
        else if (cfg_we)
        begin
            cfg_reg[cfg_index] <= cfg_data;
        end
    end

    // Input latch.
    logic [kem_pkg::OP_W-1:0]       op_reg;
    logic [kem_pkg::KEY_CODE_W-1:0] key_code_reg;
    logic [kem_pkg::SCAN_W-1:0]     query_code_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            op_reg         <= s_tuser;
            key_code_reg   <= s_tdata[kem_pkg::KEY_CODE_W-1:0];
            query_code_reg <= s_tdata[kem_pkg::KEY_CODE_W +: kem_pkg::SCAN_W];
        end
    end

    // Clear counter for the key map sweep after reset.
    logic [kem_pkg::KEY_ADDR_W-1:0] clr_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clr_wr)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    // Event assembly from the latched word and the modifier reads.
    logic [kem_pkg::SCAN_W-1:0]  raw_scan;
    logic [kem_pkg::SCAN_W-1:0]  ev_scan;
    logic                        ev_press;
    logic                        shift_reg;
    logic                        alt_reg;
    logic                        map_a_reg;
    logic                        map_b_reg;
    logic [kem_pkg::EVENT_W-1:0] ev_word;

    assign raw_scan = key_code_reg[kem_pkg::SCAN_W-1:0];

    always_comb
    begin
        if (raw_scan == kem_pkg::RAW_KP_DIV)
        begin
            ev_scan = cfg_reg[kem_pkg::REG_KP_DIV];
        end
        else if (raw_scan == kem_pkg::RAW_KP_ENTER)
        begin
            ev_scan = cfg_reg[kem_pkg::REG_KP_ENT];
        end
        else
        begin
            ev_scan = raw_scan;
        end
    end

    // A zero word is not positive, so it counts as a release.
    assign ev_press = !key_code_reg[kem_pkg::KEY_CODE_W-1] && (key_code_reg != '0);
    assign ev_word  = {map_a_reg | map_b_reg, alt_reg, shift_reg, ev_press, ev_scan};

    always_ff @(posedge clk)
    begin
        if (cmd.cap_shift)
        begin
            shift_reg <= map_a_reg | map_b_reg;
        end
        if (cmd.cap_alt)
        begin
            alt_reg <= map_a_reg | map_b_reg;
        end
    end

    // Key-down map: one write port, two registered read ports.
    logic                           key_map_mem [kem_pkg::KEY_COUNT];
    logic [kem_pkg::KEY_ADDR_W-1:0] map_addr_a;
    logic [kem_pkg::KEY_ADDR_W-1:0] map_addr_b;
    logic                           map_we;
    logic [kem_pkg::KEY_ADDR_W-1:0] map_waddr;
    logic                           map_wdata;

    always_comb
    begin
        case (cmd.map_rd_sel)
            kem_pkg::MAP_RD_SHIFT:
            begin
                map_addr_a = cfg_reg[kem_pkg::REG_LSHIFT];
                map_addr_b = cfg_reg[kem_pkg::REG_RSHIFT];
            end
            kem_pkg::MAP_RD_ALT:
            begin
                map_addr_a = cfg_reg[kem_pkg::REG_LALT];
                map_addr_b = cfg_reg[kem_pkg::REG_RALT];
            end
            kem_pkg::MAP_RD_CTRL:
            begin
                map_addr_a = cfg_reg[kem_pkg::REG_LCTRL];
                map_addr_b = cfg_reg[kem_pkg::REG_RCTRL];
            end
            default:
            begin
                map_addr_a = query_code_reg;
                map_addr_b = query_code_reg;
            end
        endcase
    end

    assign map_we    = cmd.clr_wr | cmd.push;
    assign map_waddr = cmd.clr_wr ? clr_cnt_reg : ev_scan;
    assign map_wdata = cmd.clr_wr ? 1'b0 : ev_press;

    always_ff @(posedge clk)
    begin
        if (map_we)
        begin
            key_map_mem[map_waddr] <= map_wdata;
        end
        if (cmd.map_rd)
        begin
            map_a_reg <= key_map_mem[map_addr_a];
            map_b_reg <= key_map_mem[map_addr_b];
        end
    end

    // Event FIFO pointers.
    logic [PTR_W-1:0] rd_pos_reg;
    logic [CNT_W-1:0] fill_reg;
    logic [SUM_W-1:0] wr_sum;
    logic [PTR_W-1:0] wr_pos;

    assign wr_sum = SUM_W'(rd_pos_reg) + SUM_W'(fill_reg);

    always_comb
    begin
        if (wr_sum >= SUM_W'(QUEUE_DEPTH))
        begin
            wr_pos = PTR_W'(wr_sum - SUM_W'(QUEUE_DEPTH));
        end
        else
        begin
            wr_pos = PTR_W'(wr_sum);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_pos_reg <= '0;
            fill_reg   <= '0;
        end
        else if (cmd.push)
        begin
            fill_reg <= fill_reg + 1'b1;
        end
        else if (cmd.pop)
        begin
            fill_reg <= fill_reg - 1'b1;
            if (rd_pos_reg == PTR_W'(QUEUE_DEPTH - 1))
            begin
                rd_pos_reg <= '0;
            end
            else
            begin
                rd_pos_reg <= rd_pos_reg + 1'b1;
            end
        end
    end

    // Event FIFO storage.
    logic [kem_pkg::EVENT_W-1:0] fifo_mem [QUEUE_DEPTH];
    logic [kem_pkg::EVENT_W-1:0] fifo_rd_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            fifo_mem[wr_pos] <= ev_word;
        end
        if (cmd.fifo_rd)
        begin
            fifo_rd_reg <= fifo_mem[rd_pos_reg];
        end
    end

    // Pending result, then the output register.
    logic [kem_pkg::EVENT_W-1:0]   res_event_reg;
    logic                          res_valid_reg;
    logic                          res_pressed_reg;
    logic                          res_dropped_reg;
    logic                          out_valid_reg;
    logic [kem_pkg::M_TDATA_W-1:0] out_data_reg;

    always_ff @(posedge clk)
    begin
        case (cmd.res_sel)
            kem_pkg::RES_ZERO:
            begin
                res_event_reg   <= '0;
                res_valid_reg   <= 1'b0;
                res_pressed_reg <= 1'b0;
                res_dropped_reg <= 1'b0;
            end
            kem_pkg::RES_DROP:
            begin
                res_event_reg   <= '0;
                res_valid_reg   <= 1'b0;
                res_pressed_reg <= 1'b0;
                res_dropped_reg <= 1'b1;
            end
            kem_pkg::RES_POP:
            begin
                res_event_reg   <= fifo_rd_reg;
                res_valid_reg   <= 1'b1;
                res_pressed_reg <= 1'b0;
                res_dropped_reg <= 1'b0;
            end
            kem_pkg::RES_QUERY:
            begin
                res_event_reg   <= '0;
                res_valid_reg   <= 1'b0;
                res_pressed_reg <= map_a_reg;
                res_dropped_reg <= 1'b0;
            end
            default:
            begin
            end
        endcase
        if (cmd.out_load)
        begin
            out_data_reg <= {res_dropped_reg, res_pressed_reg, res_valid_reg, res_event_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign status.op       = op_reg;
    assign status.full     = (fill_reg == CNT_W'(QUEUE_DEPTH));
    assign status.empty    = (fill_reg == '0);
    assign status.clr_last = (clr_cnt_reg == kem_pkg::KEY_ADDR_W'(kem_pkg::KEY_COUNT - 1));
    assign status.out_free = !out_valid_reg || m_tready;

endmodule
